// ----- hdl/mode_select_lifo_fifo_sorted_store_defines.svh -----
// Assertion helpers for the store RTL, used by msls_back.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MODE_SELECT_LIFO_FIFO_SORTED_STORE_DEFINES_SVH
`define MODE_SELECT_LIFO_FIFO_SORTED_STORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MSLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MSLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/msls_pkg.sv -----
`timescale 1ns / 1ps

package msls_pkg;

  localparam int VALUE_W = 32;
  localparam int FILL_W  = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Request opcodes as seen on the input channel.
  typedef logic [1:0] op_code_t;
  localparam op_code_t OP_INSERT  = 2'd0;
  localparam op_code_t OP_EXTRACT = 2'd1;
  localparam op_code_t OP_PEEK    = 2'd2;

  typedef enum logic [1:0] {
    MODE_LIFO = 2'd0,
    MODE_FIFO = 2'd1,
    MODE_SORT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    value_t    value;
  } cmd_t;

endpackage

// ----- hdl/msls_if.sv -----
`timescale 1ns / 1ps

interface msls_in_if import msls_pkg::*; ();
  logic     valid;
  logic     ready;
  op_code_t op;
  value_t   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface msls_out_if import msls_pkg::*; ();
  logic              valid;
  logic              ready;
  value_t            front_value;
  logic              is_empty;
  logic [FILL_W-1:0] fill_count;
  logic [1:0]        error_code;

  modport source (output valid, output front_value, output is_empty, output fill_count,
                  output error_code, input ready);
  modport sink   (input valid, input front_value, input is_empty, input fill_count,
                  input error_code, output ready);
endinterface

interface msls_cfg_if import msls_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

// ----- hdl/msls_front.sv -----
`timescale 1ns / 1ps

module msls_front import msls_pkg::*; (
  msls_in_if.sink in_if,
  output logic    cmd_valid,
  output cmd_t    cmd,
  input  logic    cmd_ready
);

  // Classify the request; unknown opcodes become a status-only no-op.
  always_comb begin
    cmd.value = in_if.value;
    case (in_if.op)
      OP_INSERT:  cmd.kind = CMD_INSERT;
      OP_EXTRACT: cmd.kind = CMD_EXTRACT;
      OP_PEEK:    cmd.kind = CMD_PEEK;
      default:    cmd.kind = CMD_NOP;
    endcase
  end

  assign cmd_valid   = in_if.valid;
  assign in_if.ready = cmd_ready;

endmodule

// ----- hdl/msls_cmdq.sv -----
`timescale 1ns / 1ps

module msls_cmdq import msls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_fire, pop_fire;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push_fire ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push_fire} - {1'b0, pop_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hdl/msls_back.sv -----
`timescale 1ns / 1ps
`include "mode_select_lifo_fifo_sorted_store_defines.svh"

module msls_back import msls_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  msls_cfg_if.sink    cfg_if,
  msls_out_if.source  out_if
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  mode_t             mode_r, mode_nxt;
  value_t            cell_r [DEPTH];
  value_t            cell_nxt [DEPTH];
  value_t            prev_w [DEPTH];
  value_t            succ_w [DEPTH];
  logic [DEPTH-1:0]  lt_w, ltp_w;
  logic              cmd_fire, cfg_we, full_w, empty_w, do_ins, do_ext;
  err_t              err_nxt;
  value_t            front_nxt;

  logic              out_valid_r, out_valid_nxt;
  value_t            front_value_r;
  logic              is_empty_r;
  logic [FILL_W-1:0] fill_count_r;
  err_t              error_code_r;

  assign cmd_ready    = !out_valid_r || out_if.ready;
  assign cmd_fire     = cmd_valid && cmd_ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid;
  assign full_w       = (count_r == CNT_W'(DEPTH));
  assign empty_w      = (count_r == '0);

  // Neighbor taps and the "strictly below the new value" flags of each cell.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign lt_w[g] = (CNT_W'(g) < count_r) && (cell_r[g] < cmd.value);
    if (g == 0) begin : g_first
      assign ltp_w[g]  = 1'b1;
      assign prev_w[g] = cmd.value;
    end else begin : g_rest
      assign ltp_w[g]  = lt_w[g-1];
      assign prev_w[g] = cell_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign succ_w[g] = cell_r[g];
    end else begin : g_inner
      assign succ_w[g] = cell_r[g+1];
    end
  end

  always_comb begin
    case (mode_t'(cfg_if.mode))
      MODE_FIFO: mode_nxt = MODE_FIFO;
      MODE_SORT: mode_nxt = MODE_SORT;
      default:   mode_nxt = MODE_LIFO;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    err_nxt   = ERR_OK;
    front_nxt = '0;
    do_ins    = 1'b0;
    do_ext    = 1'b0;
    if (cmd_fire) begin
      case (cmd.kind)
        CMD_INSERT: begin
          if (full_w) begin
            err_nxt = ERR_OVERFLOW;
          end else begin
            do_ins    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_EXTRACT: begin
          if (empty_w) begin
            err_nxt = ERR_UNDERFLOW;
          end else begin
            do_ext    = 1'b1;
            front_nxt = cell_r[0];
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_PEEK: begin
          if (empty_w) begin
            err_nxt = ERR_UNDERFLOW;
          end else begin
            front_nxt = cell_r[0];
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_we) begin
      count_nxt = '0;
    end
  end

  // Front always sits in cell 0: extract shifts up, insert shifts down
  // from the insertion point (top for LIFO, sorted slot) or lands at the tail.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins) begin
        case (mode_r)
          MODE_FIFO: begin
            if (CNT_W'(i) == count_r) begin
              cell_nxt[i] = cmd.value;
            end
          end
          MODE_SORT: begin
            if (!lt_w[i]) begin
              cell_nxt[i] = ltp_w[i] ? cmd.value : prev_w[i];
            end
          end
          default: cell_nxt[i] = prev_w[i];
        endcase
      end else if (do_ext) begin
        cell_nxt[i] = succ_w[i];
      end
    end
  end

  assign out_valid_nxt = cmd_fire || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mode_r      <= MODE_LIFO;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (cmd_fire) begin
      front_value_r <= front_nxt;
      is_empty_r    <= (count_nxt == '0);
      fill_count_r  <= FILL_W'(count_nxt);
      error_code_r  <= err_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.front_value = front_value_r;
  assign out_if.is_empty    = is_empty_r;
  assign out_if.fill_count  = fill_count_r;
  assign out_if.error_code  = error_code_r;

  `MSLS_ASSERT_NEXT(a_insert_grows, cmd_fire && !cfg_we && cmd.kind == CMD_INSERT && !full_w, count_r == $past(count_r) + 1'b1, "successful insert did not grow the count")
  `MSLS_ASSERT_NEXT(a_error_keeps_count, cmd_fire && !cfg_we && err_nxt != ERR_OK, count_r == $past(count_r), "rejected request changed the count")
  `MSLS_ASSERT_NEXT(a_cfg_clears, cfg_we, count_r == '0, "mode write did not empty the store")
  `MSLS_ASSERT_NOW(a_sorted_order, mode_r == MODE_SORT && count_r >= CNT_W'(2), !(cell_r[1] < cell_r[0]), "sorted store lost ascending order at the front")

endmodule

// ----- hdl/mode_select_lifo_fifo_sorted_store.sv -----
// Bounded store of up to DEPTH signed 32-bit values whose discipline is set by a
// one-register configuration port: 0 stack (LIFO), 1 queue (FIFO), 2 ascending
// sorted list that always hands out its smallest value; code 3 acts as a stack.
// Any write of the mode register empties the store, so program it before use.
// Each input item inserts, extracts or peeks (opcode 3 only reports status);
// each item yields exactly one result item: front value (zero on insert, status
// or error), an empty flag, the fill count after the step and an error code
// (underflow on extract/peek of an empty store, overflow on insert into a full
// one; the store is left untouched on error). A front stage decodes each item
// into a two-entry command queue; the back end applies it to a row of DEPTH
// cells whose front is always cell 0, with every cell comparing against the new
// value in parallel, so each command retires in a single cell update. Throughput
// is one item per clock while results are taken; an item passes the command
// queue and then the result register before its result shows on the output.
// While a result waits to be taken the back end holds, and the command queue
// absorbs up to two more items before the input stalls.
`timescale 1ns / 1ps

module mode_select_lifo_fifo_sorted_store import msls_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  msls_in_if.sink    in_if,
  msls_out_if.source out_if,
  msls_cfg_if.sink   cfg_if
);

  // Front stage to queue.
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  // Queue to back end.
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Decode items into commands.
  msls_front u_front (
    .in_if     (in_if),
    .cmd_valid (fq_valid),
    .cmd       (fq_cmd),
    .cmd_ready (fq_ready)
  );

  // Hold up to two commands so the input side and the store stall apart.
  msls_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_cmd   (fq_cmd),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_cmd    (qb_cmd),
    .pop_ready  (qb_ready)
  );

  // Apply commands to the cell row and register the result.
  msls_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd       (qb_cmd),
    .cmd_ready (qb_ready),
    .cfg_if    (cfg_if),
    .out_if    (out_if)
  );

endmodule

// ----- test/tb_mode_select_lifo_fifo_sorted_store.sv -----
`timescale 1ns / 1ps

module tb_mode_select_lifo_fifo_sorted_store;
  import msls_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1130;
  // Turn idling off for the final stretch of the random part.
  localparam int QUIET_ITEMS  = 150;
  // Margin to wait after the last result has been taken.
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 500000;

  // Opcode 3 reports status only; mode code 3 behaves as a stack.
  localparam op_code_t   OP_STATUS        = op_code_t'(CMD_NOP);
  localparam logic [1:0] MODE_ALIAS_STACK = 2'd3;

  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
  localparam value_t VALUE_MIN = 32'sh8000_0000;

  // One expected result item.
  typedef struct packed {
    value_t            front_value;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
    err_t              error_code;
  } store_result_t;

  logic clk = 1'b0;
  logic rst_n;

  msls_in_if  in_if ();
  msls_out_if out_if ();
  msls_cfg_if cfg_if ();

  mode_select_lifo_fifo_sorted_store #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always #5 clk = ~clk;

  // Predictor state: the held values and the mode register as last written.
  value_t        held_values[$];
  logic [1:0]    mode_reg = MODE_LIFO;
  store_result_t pending_results[$];

  bit          idle_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;

  // Apply one request to the predictor and return the result it should produce.
  // The held values keep insertion order for stack and queue; in sorted mode
  // they stay ascending, so the front is always entry 0 except for a stack.
  function automatic store_result_t apply_request(op_code_t op, value_t val);
    store_result_t r;
    mode_t         disc;
    int            pos;
    r = '0;
    disc = (mode_reg == MODE_FIFO || mode_reg == MODE_SORT) ? mode_t'(mode_reg) : MODE_LIFO;
    case (op)
      OP_INSERT: begin
        if (held_values.size() >= DEPTH) begin
          r.error_code = ERR_OVERFLOW;
        end else if (disc == MODE_SORT) begin
          // Place the new value after every strictly smaller one.
          pos = 0;
          while (pos < held_values.size() && held_values[pos] < val) pos++;
          held_values.insert(pos, val);
        end else begin
          held_values.push_back(val);
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (held_values.size() == 0) begin
          r.error_code = ERR_UNDERFLOW;
        end else begin
          r.front_value = (disc == MODE_LIFO) ? held_values[$] : held_values[0];
          if (op == OP_EXTRACT) begin
            if (disc == MODE_LIFO) void'(held_values.pop_back());
            else void'(held_values.pop_front());
          end
        end
      end
      default: ;
    endcase
    r.is_empty   = (held_values.size() == 0);
    r.fill_count = FILL_W'(held_values.size());
    return r;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      // Narrow range so equal values show up in sorted mode.
      2, 3:    return value_t'($urandom_range(0, 8)) - value_t'(4);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Pick an opcode with the given share of inserts, plus a few status-only items.
  function automatic op_code_t pick_op(int insert_pct);
    if ($urandom_range(0, 19) == 0) return OP_STATUS;
    if ($urandom_range(0, 99) < insert_pct) return OP_INSERT;
    return ($urandom_range(0, 2) == 0) ? OP_PEEK : OP_EXTRACT;
  endfunction

  // Send one item: optionally idle first, then hold valid until accepted and
  // queue the expected result at the accepting edge.
  task automatic push_request(op_code_t op, value_t val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.value <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(apply_request(op, val));
    items_sent++;
  endtask

  // Drop valid and hold until every queued result has been taken.
  task automatic await_all_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the mode register once the block is idle; any write empties the store.
  task automatic program_mode(logic [1:0] code);
    await_all_results();
    cfg_if.valid <= 1'b1;
    cfg_if.mode  <= code;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    mode_reg = code;
    held_values.delete();
  endtask

  task automatic flag_mismatch(string field, longint want, longint got);
    mismatch_count++;
    $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Check every result item against the oldest expectation.
  always @(posedge clk) begin
    store_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual value %0d err %0d",
                 $time, out_if.front_value, out_if.error_code);
      end else begin
        want = pending_results.pop_front();
        if (out_if.front_value !== want.front_value)
          flag_mismatch("front_value", want.front_value, out_if.front_value);
        if (out_if.is_empty !== want.is_empty)
          flag_mismatch("is_empty", want.is_empty, out_if.is_empty);
        if (out_if.fill_count !== want.fill_count)
          flag_mismatch("fill_count", want.fill_count, out_if.fill_count);
        if (out_if.error_code !== want.error_code)
          flag_mismatch("error_code", want.error_code, out_if.error_code);
      end
    end
  end

  // Result side: alternate runs of ready with random stall bursts while idling is on.
  initial out_if.ready = 1'b0;
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 16);
    end else begin
      out_if.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 30);
    end
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Right after reset the store is empty and in stack mode: extract and peek
  // must underflow, and a status-only item reports an empty store.
  task automatic test_empty_store();
    push_request(OP_EXTRACT, VALUE_MAX);
    push_request(OP_PEEK, VALUE_MIN);
    push_request(OP_STATUS, 32'sd0);
  endtask

  // Fill the sorted list to the brim with extremes and duplicates, hit
  // overflow, take the smallest, then rewrite the same mode to clear it.
  task automatic test_sorted_fill_overflow();
    value_t fill_set[DEPTH];
    fill_set = '{VALUE_MAX, VALUE_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5, -32'sd5,
                 VALUE_MAX, VALUE_MIN, 32'sh4000_0000, 32'shC000_0000, 32'sd7, 32'sd5,
                 -32'sd1, 32'sd3};
    program_mode(MODE_SORT);
    foreach (fill_set[i]) push_request(OP_INSERT, fill_set[i]);
    push_request(OP_INSERT, 32'sd0);
    push_request(OP_PEEK, 32'sd0);
    push_request(OP_EXTRACT, 32'sd0);
    program_mode(MODE_SORT);
    push_request(OP_PEEK, 32'sd0);
  endtask

  // Mode code 3 acts as a stack: the last value in comes out first.
  task automatic test_mode_three_stack();
    program_mode(MODE_ALIAS_STACK);
    push_request(OP_INSERT, 32'sd11);
    push_request(OP_INSERT, -32'sd22);
    push_request(OP_EXTRACT, 32'sd0);
  endtask

  // Random phases over every mode code. About half are fill/drain sweeps that can run
  // past full and past empty; the rest mix ops with a skewed insert share.
  task automatic test_random_phases();
    logic [1:0]  mode_cycle[4];
    int          insert_share[4];
    int unsigned start_count;
    int          phase;
    int          len;
    mode_cycle   = '{MODE_LIFO, MODE_FIFO, MODE_SORT, MODE_ALIAS_STACK};
    insert_share = '{25, 50, 70, 90};
    start_count  = items_sent;
    phase        = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      program_mode(mode_cycle[phase % 4]);
      // Some phases run without idling; the final stretch never idles.
      idle_on = (items_sent - start_count < RANDOM_ITEMS - QUIET_ITEMS) &&
                ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 1) == 0) begin
        len = $urandom_range(DEPTH - 2, DEPTH + 3);
        repeat (len) begin
          push_request(($urandom_range(0, 5) == 0) ? OP_PEEK : OP_INSERT, pick_value());
        end
        len = $urandom_range(DEPTH - 2, DEPTH + 3);
        repeat (len) begin
          push_request(($urandom_range(0, 5) == 0) ? OP_PEEK : OP_EXTRACT, pick_value());
        end
      end else begin
        len = $urandom_range(30, 60);
        for (int i = 0; i < len; i++) begin
          // Occasionally hold off the sender until the block is fully drained.
          if (i == len / 2 && $urandom_range(0, 3) == 0) await_all_results();
          push_request(pick_op(insert_share[$urandom_range(0, 3)]), pick_value());
        end
      end
      phase++;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.op     = OP_INSERT;
    in_if.value  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.mode  = MODE_LIFO;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_sorted_fill_overflow();
    test_mode_three_stack();
    test_random_phases();

    // Drain everything, then let the pipeline settle before judging.
    await_all_results();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
